[rtl/rhv_pkg.sv]
// ----------------------------------------------------------------------------
// rhv_pkg
// Shared types, constants and lookup functions of the request header validator
// ----------------------------------------------------------------------------
package rhv_pkg;

    localparam int unsigned MAX_LEN    = 4096;
    localparam int unsigned CNT_W      = $clog2(MAX_LEN + 1);
    localparam int unsigned FIELD_W    = 12;
    localparam int unsigned SCHEME_LEN = 7;
    localparam int unsigned METHOD_LEN = 3;

    localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_SLASH = 8'h2F;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_LF    = 8'h0A;

    // token counter codes
    localparam logic [2:0] TOKEN_SCHEME = 3'd0;
    localparam logic [2:0] TOKEN_METHOD = 3'd1;
    localparam logic [2:0] TOKEN_PATH   = 3'd2;
    localparam logic [2:0] TOKEN_FULL   = 3'd3;
    localparam logic [2:0] TOKEN_OVER   = 3'd4;

    localparam logic [1:0] HOLD_FULL = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_req;

    typedef struct packed {
        logic valid;
        t_req req;
    } t_req_stage;

    typedef struct packed {
        logic               done_res;
        logic               accepted;
        logic [FIELD_W-1:0] path_start;
        logic [FIELD_W-1:0] path_length;
    } t_res;

    typedef struct packed {
        logic [2:0][7:0]    hold_line;
        logic [1:0]         hold_count;
        logic               terminator_seen;
        logic               text_ended;
        logic               failed;
        logic [CNT_W-1:0]   byte_count;
        logic [2:0]         token_count;
        logic               inside_token;
        logic [2:0]         match_position;
        logic               match_good;
        logic [FIELD_W-1:0] path_offset;
        logic [FIELD_W-1:0] path_count;
    } t_state;

    localparam t_state STATE_RESET = '{
        hold_line:       '0,
        hold_count:      '0,
        terminator_seen: 1'b0,
        text_ended:      1'b0,
        failed:          1'b0,
        byte_count:      '0,
        token_count:     '0,
        inside_token:    1'b0,
        match_position:  '0,
        match_good:      1'b1,
        path_offset:     '0,
        path_count:      '0
    };

    function automatic logic [7:0] scheme_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h47;
            3'd1:    c = 8'h45;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h46;
            3'd4:    c = 8'h49;
            3'd5:    c = 8'h4C;
            3'd6:    c = 8'h45;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] method_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h47;
            3'd1:    c = 8'h45;
            3'd2:    c = 8'h54;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[rtl/rhv_if.sv]
// ----------------------------------------------------------------------------
// rhv_req_if / rhv_res_if
// Valid/ready channels carrying request bytes in and verdict items out
// ----------------------------------------------------------------------------
interface rhv_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rhv_res_if;
    logic        valid;
    logic        ready;
    logic        done_res;
    logic        accepted;
    logic [11:0] path_start;
    logic [11:0] path_length;

    modport source (output valid, output done_res, output accepted,
                    output path_start, output path_length, input ready);
    modport sink   (input valid, input done_res, input accepted,
                    input path_start, input path_length, output ready);
endinterface

[rtl/rhv_in_stage.sv]
// ----------------------------------------------------------------------------
// rhv_in_stage
// Input register for request bytes, refilled whenever the parser moves on
// ----------------------------------------------------------------------------
module rhv_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rhv_req_if.sink            i_req,
    input  logic               i_advance,
    output rhv_pkg::t_req_stage o_stage
);
    import rhv_pkg::*;

    logic r_valid;
    t_req r_req;
    logic load;

    assign load        = !r_valid || i_advance;
    assign i_req.ready = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_req.valid) begin
            r_req.data_byte <= i_req.data_byte;
            r_req.last_byte <= i_req.last_byte;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.req   = r_req;

endmodule

[rtl/rhv_parse.sv]
// ----------------------------------------------------------------------------
// rhv_parse
// Per-byte message state: hold line, terminator search, tokenizer and verdict
// ----------------------------------------------------------------------------
module rhv_parse (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rhv_pkg::t_req_stage i_stage,
    input  logic                i_advance,
    output rhv_pkg::t_res       o_res
);
    import rhv_pkg::*;

    function automatic t_state close_token(input t_state st);
        t_state r;
        r = st;
        if (r.inside_token) begin
            if (r.token_count == TOKEN_SCHEME &&
                !(r.match_good && r.match_position == 3'(SCHEME_LEN))) begin
                r.failed = 1'b1;
            end
            if (r.token_count == TOKEN_METHOD &&
                !(r.match_good && r.match_position == 3'(METHOD_LEN))) begin
                r.failed = 1'b1;
            end
            r.inside_token = 1'b0;
            if (r.token_count < TOKEN_OVER) begin
                r.token_count = r.token_count + 3'd1;
            end
        end
        return r;
    endfunction

    function automatic t_state feed_byte(input t_state st, input logic [7:0] ch,
                                         input logic [FIELD_W-1:0] off);
        t_state r;
        r = st;
        if (ch == CHR_SPACE) begin
            r = close_token(r);
        end else begin
            if (!r.inside_token) begin
                r.inside_token   = 1'b1;
                r.match_position = '0;
                r.match_good     = 1'b1;
                if (r.token_count >= TOKEN_FULL) begin
                    r.failed = 1'b1;
                end
                if (r.token_count == TOKEN_PATH) begin
                    if (ch != CHR_SLASH) begin
                        r.failed = 1'b1;
                    end
                    r.path_offset = off;
                    r.path_count  = '0;
                end
            end
            case (r.token_count)
                TOKEN_SCHEME: begin
                    if (r.match_position < 3'(SCHEME_LEN) &&
                        ch == scheme_char(r.match_position)) begin
                        r.match_position = r.match_position + 3'd1;
                    end else begin
                        r.match_good = 1'b0;
                    end
                end
                TOKEN_METHOD: begin
                    if (r.match_position < 3'(METHOD_LEN) &&
                        ch == method_char(r.match_position)) begin
                        r.match_position = r.match_position + 3'd1;
                    end else begin
                        r.match_good = 1'b0;
                    end
                end
                TOKEN_PATH: begin
                    if (r.path_count < FIELD_MAX) begin
                        r.path_count = r.path_count + FIELD_W'(1);
                    end
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    t_state             r_state;
    t_state             n_state;
    t_res               n_res;
    logic               take;
    logic [7:0]         b;
    logic [CNT_W-1:0]   pos_m3;
    logic [31:0]        pos_wide;
    logic [FIELD_W-1:0] feed_off;
    logic               term_hit;
    logic               ok;

    assign take = i_stage.valid && i_advance;
    assign b    = i_stage.req.data_byte;

    // offset of the oldest held byte, saturated to the field width
    assign pos_m3   = r_state.byte_count - CNT_W'(3);
    assign pos_wide = 32'(pos_m3);
    assign feed_off = (pos_wide > 32'(FIELD_MAX)) ? FIELD_MAX : pos_wide[FIELD_W-1:0];

    assign term_hit = r_state.hold_line[0] == CHR_CR && r_state.hold_line[1] == CHR_LF &&
                      r_state.hold_line[2] == CHR_CR && b == CHR_LF;

    always_comb begin
        n_state = r_state;
        n_res   = '0;
        ok      = 1'b0;
        if (take) begin
            if (32'(r_state.byte_count) < 32'(MAX_LEN)) begin
                n_state.byte_count = r_state.byte_count + CNT_W'(1);
            end else begin
                n_state.failed = 1'b1;
            end

            if (!r_state.text_ended) begin
                if (b == CHR_NUL) begin
                    n_state.text_ended = 1'b1;
                end else if (r_state.terminator_seen) begin
                    n_state.failed = 1'b1;
                end else if (r_state.hold_count == HOLD_FULL) begin
                    if (term_hit) begin
                        n_state.terminator_seen = 1'b1;
                        n_state.hold_count      = '0;
                    end else begin
                        n_state = feed_byte(n_state, r_state.hold_line[0], feed_off);
                        n_state.hold_line[0] = r_state.hold_line[1];
                        n_state.hold_line[1] = r_state.hold_line[2];
                        n_state.hold_line[2] = b;
                    end
                end else begin
                    case (r_state.hold_count)
                        2'd0:    n_state.hold_line[0] = b;
                        2'd1:    n_state.hold_line[1] = b;
                        default: n_state.hold_line[2] = b;
                    endcase
                    n_state.hold_count = r_state.hold_count + 2'd1;
                end
            end

            if (i_stage.req.last_byte) begin
                n_state = close_token(n_state);
                ok = !n_state.failed && n_state.terminator_seen &&
                     n_state.token_count == TOKEN_FULL;
                n_res.done_res    = 1'b1;
                n_res.accepted    = ok;
                n_res.path_start  = ok ? n_state.path_offset : '0;
                n_res.path_length = ok ? n_state.path_count : '0;
                n_state = STATE_RESET;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_res = n_res;

endmodule

[rtl/rhv_out_stage.sv]
// ----------------------------------------------------------------------------
// rhv_out_stage
// Result register holding one verdict item until the sink takes it
// ----------------------------------------------------------------------------
module rhv_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  rhv_pkg::t_res       i_res,
    output logic                o_advance,
    rhv_res_if.source           o_res
);
    import rhv_pkg::*;

    logic r_valid;
    t_res r_res;

    assign o_advance = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.done_res    = r_res.done_res;
    assign o_res.accepted    = r_res.accepted;
    assign o_res.path_start  = r_res.path_start;
    assign o_res.path_length = r_res.path_length;

endmodule

[rtl/request_header_validator.sv]
// ----------------------------------------------------------------------------
// request_header_validator
// Checks a byte-wise request message and reports verdict and path location
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                      | item
//  i_req    | in  | data_byte[7:0], last_byte                    | one message byte
//  o_res    | out | done_res, accepted, path_start, path_length  | one result per byte
//
//  one byte per clock while o_res does not stall; each taken byte passes the input
//  register, then the result register, which holds its result until it is accepted
//  synchronous active-low reset clears the message state and both stage valids
//  a stall on o_res holds the result register and backs up through the input
//  register; bytes keep flowing while the result register drains
// ----------------------------------------------------------------------------
module request_header_validator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rhv_req_if.sink   i_req,
    rhv_res_if.source o_res
);
    import rhv_pkg::*;

    t_req_stage stage;
    t_res       res;
    logic       advance;

    rhv_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_advance (advance),
        .o_stage   (stage)
    );

    rhv_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_stage   (stage),
        .i_advance (advance),
        .o_res     (res)
    );

    rhv_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (stage.valid),
        .i_res     (res),
        .o_advance (advance),
        .o_res     (o_res)
    );

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid straight after reset");

    a_verdict_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.done_res |->
            !o_res.accepted && o_res.path_start == '0 && o_res.path_length == '0)
        else $error("verdict fields set on a non-final item");

    a_path_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.accepted |-> o_res.path_length != '0)
        else $error("accepted message with empty path");

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stage.valid && advance |=> o_res.valid)
        else $error("parsed item lost before result register");
`endif

endmodule
